>>> rtl/rvd_pkg.sv
package rvd_pkg;

    typedef enum logic [5:0] {
        MN_LUI, MN_AUIPC, MN_J, MN_CALL, MN_JAL,
        MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU,
        MN_LB, MN_LH, MN_LW, MN_LBU, MN_LHU,
        MN_RET, MN_JALR,
        MN_ADDI, MN_XORI, MN_ORI, MN_ANDI, MN_SLLI,
        MN_SRLI, MN_SRAI, MN_SLTI, MN_SLTIU,
        MN_SB, MN_SH, MN_SW,
        MN_ADD, MN_SUB, MN_XOR, MN_OR, MN_AND, MN_SLL,
        MN_SRL, MN_SRA, MN_SLT, MN_SLTU,
        MN_MUL, MN_MULH, MN_MULHSU, MN_MULHU, MN_DIV,
        MN_DIVU, MN_REM, MN_REMU,
        MN_ECALL, MN_NONE, MN_UNKNOWN
    } t_mnemonic;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_SYSTEM = 7'h73;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_REG    = 7'h33;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT    = 7'h20;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;

    localparam logic [2:0] F3_SB = 3'd0;
    localparam logic [2:0] F3_SH = 3'd1;
    localparam logic [2:0] F3_SW = 3'd2;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_MUL    = 3'd0;
    localparam logic [2:0] F3_MULH   = 3'd1;
    localparam logic [2:0] F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_MULHU  = 3'd3;
    localparam logic [2:0] F3_DIV    = 3'd4;
    localparam logic [2:0] F3_DIVU   = 3'd5;
    localparam logic [2:0] F3_REM    = 3'd6;
    localparam logic [2:0] F3_REMU   = 3'd7;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 88;

    typedef struct packed {
        logic [31:0]        target_address;
        logic signed [31:0] immediate;
        logic [4:0]         src2_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         dest_reg;
        t_mnemonic          mnemonic;
    } t_dec_result;

endpackage

>>> rtl/rvd_decode.sv
module rvd_decode (
    input  logic [31:0]         i_pc_address,
    input  logic [31:0]         i_instr_word,
    output rvd_pkg::t_dec_result o_result
);
    import rvd_pkg::*;

    logic [6:0]  opcode;
    logic [4:0]  rd;
    logic [2:0]  funct3;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [6:0]  funct7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;
    logic [31:0] imm_shamt;
    logic [31:0] branch_sum;
    logic [31:0] jump_sum;

    assign opcode = i_instr_word[6:0];
    assign rd     = i_instr_word[11:7];
    assign funct3 = i_instr_word[14:12];
    assign rs1    = i_instr_word[19:15];
    assign rs2    = i_instr_word[24:20];
    assign funct7 = i_instr_word[31:25];

    assign imm_i = {{20{i_instr_word[31]}}, i_instr_word[31:20]};
    assign imm_s = {{20{i_instr_word[31]}}, i_instr_word[31:25], i_instr_word[11:7]};
    assign imm_b = {{19{i_instr_word[31]}}, i_instr_word[31], i_instr_word[7],
                    i_instr_word[30:25], i_instr_word[11:8], 1'b0};
    assign imm_j = {{11{i_instr_word[31]}}, i_instr_word[31], i_instr_word[19:12],
                    i_instr_word[20], i_instr_word[30:21], 1'b0};
    assign imm_u     = {12'd0, i_instr_word[31:12]};
    assign imm_shamt = {27'd0, rs2};

    assign branch_sum = i_pc_address + imm_b;
    assign jump_sum   = i_pc_address + imm_j;

    always_comb begin
        o_result = '0;
        o_result.mnemonic = MN_UNKNOWN;
        case (opcode)
            OP_LUI, OP_AUIPC: begin
                o_result.mnemonic  = (opcode == OP_LUI) ? MN_LUI : MN_AUIPC;
                o_result.dest_reg  = rd;
                o_result.immediate = imm_u;
            end
            OP_JAL: begin
                if (rd == REG_ZERO) begin
                    o_result.mnemonic = MN_J;
                end else if (rd == REG_RA) begin
                    o_result.mnemonic = MN_CALL;
                end else begin
                    o_result.mnemonic = MN_JAL;
                end
                o_result.dest_reg       = rd;
                o_result.immediate      = imm_j;
                o_result.target_address = jump_sum;
            end
            OP_BRANCH: begin
                case (funct3)
                    F3_BEQ:  o_result.mnemonic = MN_BEQ;
                    F3_BNE:  o_result.mnemonic = MN_BNE;
                    F3_BLT:  o_result.mnemonic = MN_BLT;
                    F3_BGE:  o_result.mnemonic = MN_BGE;
                    F3_BLTU: o_result.mnemonic = MN_BLTU;
                    F3_BGEU: o_result.mnemonic = MN_BGEU;
                    default: o_result.mnemonic = MN_NONE;
                endcase
                if (o_result.mnemonic != MN_NONE) begin
                    o_result.src1_reg       = rs1;
                    o_result.src2_reg       = rs2;
                    o_result.immediate      = imm_b;
                    o_result.target_address = branch_sum;
                end
            end
            OP_JALR: begin
                if (rd == REG_ZERO && rs1 == REG_RA && i_instr_word[31:20] == 12'd0) begin
                    o_result.mnemonic = MN_RET;
                end else begin
                    o_result.mnemonic = MN_JALR;
                end
                o_result.dest_reg  = rd;
                o_result.src1_reg  = rs1;
                o_result.immediate = imm_i;
            end
            OP_LOAD: begin
                case (funct3)
                    F3_LB:   o_result.mnemonic = MN_LB;
                    F3_LH:   o_result.mnemonic = MN_LH;
                    F3_LW:   o_result.mnemonic = MN_LW;
                    F3_LBU:  o_result.mnemonic = MN_LBU;
                    F3_LHU:  o_result.mnemonic = MN_LHU;
                    default: o_result.mnemonic = MN_NONE;
                endcase
                if (o_result.mnemonic != MN_NONE) begin
                    o_result.dest_reg  = rd;
                    o_result.src1_reg  = rs1;
                    o_result.immediate = imm_i;
                end
            end
            OP_IMM: begin
                case (funct3)
                    F3_ADD:  o_result.mnemonic = MN_ADDI;
                    F3_SLL:  o_result.mnemonic = (funct7 == F7_BASE) ? MN_SLLI : MN_NONE;
                    F3_SLT:  o_result.mnemonic = MN_SLTI;
                    F3_SLTU: o_result.mnemonic = MN_SLTIU;
                    F3_XOR:  o_result.mnemonic = MN_XORI;
                    F3_SR: begin
                        if (funct7 == F7_BASE) begin
                            o_result.mnemonic = MN_SRLI;
                        end else if (funct7 == F7_ALT) begin
                            o_result.mnemonic = MN_SRAI;
                        end else begin
                            o_result.mnemonic = MN_NONE;
                        end
                    end
                    F3_OR:   o_result.mnemonic = MN_ORI;
                    F3_AND:  o_result.mnemonic = MN_ANDI;
                    default: o_result.mnemonic = MN_NONE;
                endcase
                if (o_result.mnemonic != MN_NONE) begin
                    o_result.dest_reg  = rd;
                    o_result.src1_reg  = rs1;
                    o_result.immediate = (funct3 == F3_SLL || funct3 == F3_SR) ?
                                         imm_shamt : imm_i;
                end
            end
            OP_SYSTEM: begin
                o_result.mnemonic = MN_ECALL;
            end
            OP_STORE: begin
                case (funct3)
                    F3_SB:   o_result.mnemonic = MN_SB;
                    F3_SH:   o_result.mnemonic = MN_SH;
                    F3_SW:   o_result.mnemonic = MN_SW;
                    default: o_result.mnemonic = MN_NONE;
                endcase
                if (o_result.mnemonic != MN_NONE) begin
                    o_result.src1_reg  = rs1;
                    o_result.src2_reg  = rs2;
                    o_result.immediate = imm_s;
                end
            end
            OP_REG: begin
                if (funct7 == F7_MULDIV) begin
                    case (funct3)
                        F3_MUL:    o_result.mnemonic = MN_MUL;
                        F3_MULH:   o_result.mnemonic = MN_MULH;
                        F3_MULHSU: o_result.mnemonic = MN_MULHSU;
                        F3_MULHU:  o_result.mnemonic = MN_MULHU;
                        F3_DIV:    o_result.mnemonic = MN_DIV;
                        F3_DIVU:   o_result.mnemonic = MN_DIVU;
                        F3_REM:    o_result.mnemonic = MN_REM;
                        F3_REMU:   o_result.mnemonic = MN_REMU;
                        default:   o_result.mnemonic = MN_NONE;
                    endcase
                end else begin
                    case (funct3)
                        F3_ADD:  o_result.mnemonic = (funct7 == F7_BASE) ? MN_ADD : MN_SUB;
                        F3_SLL:  o_result.mnemonic = MN_SLL;
                        F3_SLT:  o_result.mnemonic = MN_SLT;
                        F3_SLTU: o_result.mnemonic = MN_SLTU;
                        F3_XOR:  o_result.mnemonic = MN_XOR;
                        F3_SR:   o_result.mnemonic = (funct7 == F7_BASE) ? MN_SRL : MN_SRA;
                        F3_OR:   o_result.mnemonic = MN_OR;
                        F3_AND:  o_result.mnemonic = MN_AND;
                        default: o_result.mnemonic = MN_NONE;
                    endcase
                end
                o_result.dest_reg = rd;
                o_result.src1_reg = rs1;
                o_result.src2_reg = rs2;
            end
            default: begin
                o_result.mnemonic = MN_UNKNOWN;
            end
        endcase
    end

endmodule

>>> rtl/rv32im_instruction_decoder.sv
// Decodes one RV32IM instruction word per beat into a mnemonic code, register numbers,
// the immediate and, for branches and JAL forms, the target address. The block takes a
// new beat every cycle unless the output is stalled with the input register full. An accepted
// beat is held in the input register while the field decode and the two 32-bit target adders,
// one for branches and one for JAL, work on it. The result register then loads the decoded
// fields, and the result is offered from there. When the output is stalled the result
// register holds, as does a full input register, and o_s_tready follows i_m_tready
// combinationally once the pipeline is full.
module rv32im_instruction_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // pc_address [31:0], instr_word [63:32]
    input  logic [rvd_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // mnemonic [5:0], dest_reg [10:6], src1_reg [15:11], src2_reg [20:16],
    // immediate [52:21], target_address [84:53], zero [87:85]
    output logic [rvd_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import rvd_pkg::*;

    logic        r_s1_valid;
    logic        n_s1_valid;
    logic [31:0] r_pc;
    logic [31:0] r_word;
    logic        r_out_valid;
    logic        n_out_valid;
    t_dec_result r_out;
    t_dec_result dec_result;
    logic        out_free;
    logic        s1_adv;
    logic        in_acc;

    assign out_free   = !r_out_valid || i_m_tready;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_s_tready = !r_s1_valid || out_free;
    assign in_acc     = i_s_tvalid && o_s_tready;

    assign n_s1_valid  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : r_s1_valid);
    assign n_out_valid = s1_adv ? 1'b1 : (i_m_tready ? 1'b0 : r_out_valid);

    rvd_decode u_decode (
        .i_pc_address (r_pc),
        .i_instr_word (r_word),
        .o_result     (dec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pc   <= i_s_tdata[31:0];
            r_word <= i_s_tdata[63:32];
        end
        if (s1_adv) begin
            r_out <= dec_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'd0, r_out.target_address, r_out.immediate, r_out.src2_reg,
                         r_out.src1_reg, r_out.dest_reg, r_out.mnemonic};

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |=> r_s1_valid && $stable(r_word) && $stable(r_pc))
        else $error("input register changed while the output was stalled");

    a_blank_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.mnemonic == MN_NONE || r_out.mnemonic == MN_UNKNOWN ||
                        r_out.mnemonic == MN_ECALL)
        |-> r_out.dest_reg == 5'd0 && r_out.src1_reg == 5'd0 && r_out.src2_reg == 5'd0 &&
            r_out.immediate == 32'sd0 && r_out.target_address == 32'd0)
        else $error("fields not cleared for a result without operands");

    a_target_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.target_address != 32'd0
        |-> r_out.mnemonic >= MN_J && r_out.mnemonic <= MN_BGEU)
        else $error("target address given for an instruction that is not a branch or jump");

    a_mnemonic_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.mnemonic <= MN_UNKNOWN)
        else $error("mnemonic code out of range");

endmodule
